@@ hw/rtl/auto_reload_soft_timer_bank_assert.svh @@
// Assertion macros used by the timer bank top module.
`ifndef AUTO_RELOAD_SOFT_TIMER_BANK_ASSERT_SVH
`define AUTO_RELOAD_SOFT_TIMER_BANK_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is high.
`define ARSTB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
// Clocked check that also runs through reset.
`define ARSTB_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");
`else
`define ARSTB_ASSERT(lbl, clk, rst, prop)
`define ARSTB_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ hw/rtl/arstb_pkg.sv @@
// Package with the types and constants of the auto-reload timer bank.
package arstb_pkg;

   localparam int NUM_TIMERS = 10;
   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [8:0] IDX_LIMIT = 9'(NUM_TIMERS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_SET  = 2'd1;
   localparam logic [1:0] FUNC_POLL = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  timer_index;
      logic [15:0] load_value;
   } req_type;

   typedef struct packed {
      logic        expired;
      logic [31:0] tick_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] preset;
      logic [15:0] current;
   } store_entry_type;

   typedef struct packed {
      logic            en;
      logic [IDX_W-1:0] addr;
      store_entry_type data;
   } store_wr_type;

endpackage

@@ hw/rtl/arstb_count_store.sv @@
// Timer count memory with per-entry valid bits and a registered read.
module arstb_count_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [arstb_pkg::IDX_W-1:0]   rd_addr,
   input  arstb_pkg::store_wr_type       wr,
   output arstb_pkg::store_entry_type    rd_data
);

   arstb_pkg::store_entry_type entry_mem [arstb_pkg::NUM_TIMERS];
   arstb_pkg::store_entry_type rd_q_ff;
   logic [arstb_pkg::NUM_TIMERS-1:0] vld_ff;
   logic rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_q_ff <= entry_mem[rd_addr];
      end
   end

   // An entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

@@ hw/rtl/auto_reload_soft_timer_bank.sv @@
// A set or poll item passes through the ST_MOD and ST_DONE states before its result is
// registered at the output. A tick item walks all NUM_TIMERS entries, one read per cycle,
// through the count memory read port, then passes ST_DRAIN and ST_DONE.
// One item is in work at a time; a new item is taken only once the last has left ST_DONE.
// Reset clears the tick counter and all timer valid bits; no
// clearing pass is needed, an unwritten timer reads as zero.
`include "auto_reload_soft_timer_bank_assert.svh"

module auto_reload_soft_timer_bank (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  arstb_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output arstb_pkg::rsp_type  rsp_data
);

   // One-hot sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MOD   = 5'b00010,
      ST_WALK  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   arstb_pkg::req_type item_ff, item_in;
   logic item_ok_ff, item_ok_in;
   logic [arstb_pkg::IDX_W-1:0] walk_cnt_ff, walk_cnt_in;
   logic wr_pend_ff, wr_pend_in;
   logic [arstb_pkg::IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic hit_ff, hit_in;
   logic rsp_valid_ff, rsp_valid_in;
   arstb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic idx_ok;
   logic rd_en;
   logic [arstb_pkg::IDX_W-1:0] rd_addr;
   arstb_pkg::store_wr_type wr;
   arstb_pkg::store_entry_type rd_data;

   // The bank takes a new item only when the sequencer is idle. The output
   // register still lets a finished result wait while the next item runs.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign idx_ok    = ({1'b0, req_data.timer_index} < arstb_pkg::IDX_LIMIT);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   arstb_count_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      item_ok_in   = item_ok_ff;
      walk_cnt_in  = walk_cnt_ff;
      wr_pend_in   = 1'b0;
      wr_idx_in    = wr_idx_ff;
      elapsed_in   = elapsed_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = req_data.timer_index[arstb_pkg::IDX_W-1:0];
      wr.en        = 1'b0;
      wr.addr      = wr_idx_ff;
      wr.data      = rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in    = req_data;
               item_ok_in = idx_ok;
               hit_in     = 1'b0;
               if (req_data.func == arstb_pkg::FUNC_TICK) begin
                  elapsed_in  = elapsed_ff + 32'd1;
                  walk_cnt_in = '0;
                  state_in    = ST_WALK;
               end else begin
                  // A poll fetches its entry now so the data is ready next cycle.
                  rd_en    = (req_data.func == arstb_pkg::FUNC_POLL) && idx_ok;
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            wr.addr = item_ff.timer_index[arstb_pkg::IDX_W-1:0];
            case (item_ff.func)
               arstb_pkg::FUNC_SET: begin
                  if (item_ok_ff) begin
                     wr.en           = 1'b1;
                     wr.data.preset  = item_ff.load_value + 16'd1;
                     wr.data.current = item_ff.load_value + 16'd1;
                  end
               end
               arstb_pkg::FUNC_POLL: begin
                  // An expired timer reloads its count from the preset.
                  if (item_ok_ff && (rd_data.current == 16'd1)) begin
                     wr.en           = 1'b1;
                     wr.data.current = rd_data.preset;
                     hit_in          = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            state_in = ST_DONE;
         end
         ST_WALK: begin
            // Read entry k while entry k-1 is written back.
            rd_en      = 1'b1;
            rd_addr    = walk_cnt_ff;
            wr_pend_in = 1'b1;
            wr_idx_in  = walk_cnt_ff;
            if (walk_cnt_ff == arstb_pkg::LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               walk_cnt_in = walk_cnt_ff + arstb_pkg::IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.expired    = hit_ff;
               rsp_data_in.tick_count = elapsed_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Tick write-back stage: a count above one steps down, one and zero hold.
      if (wr_pend_ff && (rd_data.current > 16'd1)) begin
         wr.en           = 1'b1;
         wr.addr         = wr_idx_ff;
         wr.data.preset  = rd_data.preset;
         wr.data.current = rd_data.current - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_cnt_ff  <= '0;
         wr_pend_ff   <= 1'b0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_cnt_ff  <= walk_cnt_in;
         wr_pend_ff   <= wr_pend_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      item_ok_ff  <= item_ok_in;
      wr_idx_ff   <= wr_idx_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A tick bumps the counter by exactly one.
   `ARSTB_ASSERT(a_tick_count, clock, reset, (accept && (req_data.func == arstb_pkg::FUNC_TICK)) |=> (elapsed_ff == $past(elapsed_ff) + 32'd1))
   // The memory is written only while an item is being worked on.
   `ARSTB_ASSERT(a_wr_state, clock, reset, wr.en |-> (state_ff == ST_MOD || state_ff == ST_WALK || state_ff == ST_DRAIN))
   // The walk never reads the entry that it writes in the same cycle.
   `ARSTB_ASSERT(a_no_rw_clash, clock, reset, (wr.en && rd_en) |-> (wr.addr != rd_addr))
   // Reset leaves the sequencer idle with no result pending.
   `ARSTB_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> ((state_ff == ST_IDLE) && !rsp_valid_ff))

endmodule

@@ tb/timer_bank_tracker_pkg.sv @@
// Scoreboard class that tracks the timer bank state and checks each response item.
package timer_bank_tracker_pkg;

   import arstb_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   class timer_bank_tracker;
      logic [15:0] preset_ticks [NUM_TIMERS];
      logic [15:0] count_ticks [NUM_TIMERS];
      logic [31:0] tick_total;
      rsp_type     status_due [$];
      int unsigned errors;

      function new();
         for (int k = 0; k < NUM_TIMERS; k++) begin
            preset_ticks[k] = '0;
            count_ticks[k] = '0;
         end
         tick_total = '0;
         errors = 0;
      endfunction

      function int pending();
         return status_due.size();
      endfunction

      // Advance the tracked state by one accepted request item and queue its response.
      function void apply_item(req_type item);
         rsp_type     status;
         int          slot;
         logic [15:0] period;
         status.expired = 1'b0;
         slot = int'(item.timer_index);
         case (item.func)
            FUNC_TICK: begin
               tick_total = tick_total + 32'd1;
               for (int k = 0; k < NUM_TIMERS; k++) begin
                  if (count_ticks[k] > 16'd1) count_ticks[k] = count_ticks[k] - 16'd1;
               end
            end
            FUNC_SET: begin
               if (slot < NUM_TIMERS) begin
                  period = item.load_value + 16'd1;
                  preset_ticks[slot] = period;
                  count_ticks[slot] = period;
               end
            end
            FUNC_POLL: begin
               if (slot < NUM_TIMERS && count_ticks[slot] == 16'd1) begin
                  count_ticks[slot] = preset_ticks[slot];
                  status.expired = 1'b1;
               end
            end
            default: begin
            end
         endcase
         status.tick_count = tick_total;
         status_due.push_back(status);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // Compare one accepted response item with the oldest queued one.
      task check_status(rsp_type got);
         rsp_type want;
         if (status_due.size() == 0) begin
            report($sformatf("response with nothing outstanding: expired %0b tick_count %0d",
                             got.expired, got.tick_count));
         end else begin
            want = status_due.pop_front();
            if (got.expired !== want.expired)
               report($sformatf("expired got %0b want %0b", got.expired, want.expired));
            if (got.tick_count !== want.tick_count)
               report($sformatf("tick_count got %0d want %0d",
                                got.tick_count, want.tick_count));
         end
      endtask
   endclass

endpackage

@@ tb/tb.sv @@
// Top-level testbench for the auto-reload soft timer bank.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import arstb_pkg::*;
   import timer_bank_tracker_pkg::*;

   // Number of random request items after the directed part.
   localparam int RANDOM_ITEMS = 1100;
   // The last items of the run go through with no idling on either side.
   localparam int CALM_ITEMS = 150;
   // A tick is the slowest item; give the tail a few of those after the drain.
   localparam int DRAIN_CYCLES = 4 * (NUM_TIMERS + 3);
   // Cycles with no handshake on either channel before the run is abandoned.
   localparam int STUCK_LIMIT = 2000;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   bit      calm = 1'b0;
   int      quiet_cycles = 0;

   timer_bank_tracker tracker = new();

   auto_reload_soft_timer_bank dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Free-running clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Present one request item at the falling edge and hold it until the block
   // takes it. The item is handed to the tracker at the rising edge of acceptance.
   task send_item(input logic [1:0] func, input logic [7:0] index, input logic [15:0] load);
      req_type item;
      item.func = func;
      item.timer_index = index;
      item.load_value = load;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      tracker.apply_item(item);
   endtask

   // Now and then drop valid for a short burst, so that gaps land on every
   // phase of the block's work. Nothing happens once the calm part has begun.
   task maybe_pause();
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Random item. Most indexes hit a real timer and most periods are short, so
   // that timers actually count down to one and expire between polls. A few
   // items use any index or any period so that every bit of each field moves.
   task send_random_item();
      int          pick;
      logic [1:0]  func;
      logic [7:0]  index;
      logic [15:0] load;
      pick = $urandom_range(0, 99);
      if (pick < 40) func = FUNC_TICK;
      else if (pick < 58) func = FUNC_SET;
      else if (pick < 95) func = FUNC_POLL;
      else func = FUNC_UNUSED;
      if ($urandom_range(0, 9) == 0) index = 8'($urandom_range(0, 255));
      else index = 8'($urandom_range(0, NUM_TIMERS - 1));
      pick = $urandom_range(0, 9);
      if (pick < 6) load = 16'($urandom_range(0, 6));
      else if (pick < 8) load = 16'($urandom_range(0, 40));
      else if (pick == 8) load = 16'($urandom);
      else load = 16'hFFFF;
      send_item(func, index, load);
   endtask

   // Responses are taken at the rising edge and checked against the tracker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_status(rsp_data);
   end

   // The response side stalls in random bursts, except during
   // the calm part at the end of the run.
   initial begin
      int burst;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 6) == 0) begin
            burst = $urandom_range(1, 6);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STUCK_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. A poll on a timer that was never set must not expire.
      send_item(FUNC_POLL, 8'd0, 16'd0);
      maybe_pause();
      send_item(FUNC_TICK, 8'd0, 16'd0);
      // A period of zero loads one, so the timer is expired right away, and
      // after the reload from its preset it is expired again on the next poll.
      send_item(FUNC_SET, 8'd0, 16'd0);
      send_item(FUNC_POLL, 8'd0, 16'd0);
      send_item(FUNC_POLL, 8'd0, 16'd0);
      maybe_pause();
      // The largest period wraps to zero; such a timer never counts or expires.
      send_item(FUNC_SET, 8'd1, 16'hFFFF);
      send_item(FUNC_TICK, 8'd1, 16'hFFFF);
      send_item(FUNC_POLL, 8'd1, 16'd0);
      // Count down to one, then tick once more: the timer holds at one until
      // it is polled. Timer 0 also sits at one through these ticks.
      send_item(FUNC_SET, 8'd2, 16'd2);
      send_item(FUNC_TICK, 8'd0, 16'd0);
      send_item(FUNC_TICK, 8'd0, 16'd0);
      maybe_pause();
      send_item(FUNC_TICK, 8'd0, 16'd0);
      send_item(FUNC_POLL, 8'd2, 16'd0);
      send_item(FUNC_POLL, 8'd0, 16'd0);
      // The last real timer works like the others.
      send_item(FUNC_SET, 8'(NUM_TIMERS - 1), 16'd0);
      send_item(FUNC_POLL, 8'(NUM_TIMERS - 1), 16'd0);
      // Indexes past the last timer are ignored by set and poll alike.
      send_item(FUNC_SET, 8'(NUM_TIMERS), 16'd5);
      send_item(FUNC_POLL, 8'(NUM_TIMERS), 16'd0);
      send_item(FUNC_SET, 8'hFF, 16'hFFFF);
      send_item(FUNC_POLL, 8'hFF, 16'd0);
      // The unused function code changes nothing and reports the tick count.
      send_item(FUNC_UNUSED, 8'hFF, 16'hFFFF);
      send_item(FUNC_UNUSED, 8'd0, 16'd0);
      maybe_pause();
      // Alternating bit patterns in the period.
      send_item(FUNC_SET, 8'd3, 16'h5555);
      send_item(FUNC_SET, 8'd4, 16'hAAAA);
      send_item(FUNC_TICK, 8'hAA, 16'h5555);

      // Random part, with the last stretch free of idling on both sides.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         send_random_item();
         maybe_pause();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Let every outstanding response arrive, then give the block a few more
      // cycles in which any stray response would be caught.
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
